[src/i2c_master_transaction_sequencer_macros.svh]
// assertion macros for the i2c sequencer
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH

// checked outside reset
`define I2C_SEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked at every edge
`define I2C_SEQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[src/i2c_seq_pkg.sv]
`default_nettype none

package i2c_seq_pkg;

    typedef enum logic [1:0] {
        ACT_STEP  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_RDREG = 2'd2,
        ACT_RSVD  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_START   = 3'd1,
        PH_WREG    = 3'd2,
        PH_RESTART = 3'd3,
        PH_READ    = 3'd4,
        PH_WDATA   = 3'd5,
        PH_STOP    = 3'd6,
        PH_ERROR   = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        PRIM_START   = 3'd0,
        PRIM_RESTART = 3'd1,
        PRIM_WRITE   = 3'd2,
        PRIM_READ    = 3'd3,
        PRIM_STOP    = 3'd4,
        PRIM_NONE    = 3'd5
    } t_prim;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BUSY  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    localparam logic [1:0] RES_OK   = 2'd0;
    localparam logic [1:0] RES_NACK = 2'd1;

    localparam logic [7:0] READ_FLAG = 8'h01;

    localparam int IDX_W   = 16;
    localparam int MAX_RES = 3;

    typedef struct packed {
        t_action          action;
        logic [7:0]       device_address;
        logic [7:0]       register_index;
        logic [IDX_W-1:0] length;
        logic [1:0]       first_result;
        logic [1:0]       second_result;
        logic [7:0]       buffer_byte;
        logic [7:0]       read_byte;
    } t_req;

    typedef struct packed {
        t_prim            primitive_res;
        logic [7:0]       bus_byte;
        logic [IDX_W-1:0] transfer_index;
        t_status          status;
        logic             last;
    } t_res;

endpackage

`default_nettype wire

[src/i2c_master_transaction_sequencer.sv]
// channel   | valid        | ready        | payload
// request   | i_req_valid  | o_req_ready  | i_req  (i2c_seq_pkg::t_req)
// result    | o_res_valid  | i_res_ready  | o_res  (i2c_seq_pkg::t_res)
//
// each request is decoded in the cycle it is taken; state and its 1 to 3 results
// are registered at that edge; results leave one per cycle while i_res_ready
// is high. a request yielding one result can be taken every cycle while results
// are taken; one yielding more holds the next request while the buffer drains.
// ready is high when the buffer is empty or its final entry is being taken.
// i_rst_n is synchronous, active low; it returns the sequencer to idle.
`default_nettype none

`include "i2c_master_transaction_sequencer_macros.svh"

module i2c_master_transaction_sequencer #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_valid,
    output logic                o_req_ready,
    input  wire i2c_seq_pkg::t_req i_req,
    output logic                o_res_valid,
    input  wire                 i_res_ready,
    output i2c_seq_pkg::t_res   o_res
);

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    i2c_seq_pkg::t_phase   r_phase, n_phase;
    logic                  r_is_rdreg, n_is_rdreg;
    logic [7:0]            r_addr, n_addr;
    logic [7:0]            r_reg, n_reg;
    logic [COUNT_WIDTH-1:0] r_done, n_done;
    logic [COUNT_WIDTH-1:0] r_total, n_total;

    i2c_seq_pkg::t_res     r_res [i2c_seq_pkg::MAX_RES];
    i2c_seq_pkg::t_res     n_res [i2c_seq_pkg::MAX_RES];
    logic [1:0]            r_left;
    logic [1:0]            n_num;

    logic                  in_acc, out_acc;
    logic                  is_cmd, is_step;
    logic [COUNT_WIDTH-1:0] len, done_inc;
    logic [i2c_seq_pkg::IDX_W-1:0] idx_ext;
    i2c_seq_pkg::t_status  n_status;

    assign in_acc      = i_req_valid && o_req_ready;
    assign out_acc     = o_res_valid && i_res_ready;
    assign o_res_valid = (r_left != 2'd0);
    assign o_req_ready = (r_left == 2'd0) || ((r_left == 2'd1) && i_res_ready);
    assign o_res       = r_res[0];

    assign is_cmd   = (i_req.action == i2c_seq_pkg::ACT_WRITE)
                   || (i_req.action == i2c_seq_pkg::ACT_RDREG);
    assign is_step  = (i_req.action == i2c_seq_pkg::ACT_STEP)
                   && (r_phase != i2c_seq_pkg::PH_IDLE)
                   && (r_phase != i2c_seq_pkg::PH_ERROR);
    assign len      = i_req.length[COUNT_WIDTH-1:0];
    assign done_inc = r_done + CNT_ONE;
    assign idx_ext  = i2c_seq_pkg::IDX_W'(r_done);

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_is_rdreg = r_is_rdreg;
        n_addr     = r_addr;
        n_reg      = r_reg;
        n_done     = r_done;
        n_total    = r_total;
        if (is_cmd) begin
            if ((r_phase == i2c_seq_pkg::PH_IDLE) || (r_phase == i2c_seq_pkg::PH_ERROR)) begin
                n_addr     = i_req.device_address;
                n_reg      = i_req.register_index;
                n_total    = (len == '0) ? CNT_ONE : len;
                n_done     = '0;
                n_is_rdreg = (i_req.action == i2c_seq_pkg::ACT_RDREG);
                n_phase    = i2c_seq_pkg::PH_START;
            end
        end else if (is_step) begin
            case (r_phase)
                i2c_seq_pkg::PH_START, i2c_seq_pkg::PH_RESTART: begin
                    if (i_req.first_result == i2c_seq_pkg::RES_OK) begin
                        if (i_req.second_result != i2c_seq_pkg::RES_OK) begin
                            n_phase = i2c_seq_pkg::PH_ERROR;
                        end else if (r_phase == i2c_seq_pkg::PH_RESTART) begin
                            n_phase = i2c_seq_pkg::PH_READ;
                        end else if (r_is_rdreg) begin
                            n_phase = i2c_seq_pkg::PH_WREG;
                        end else begin
                            n_phase = i2c_seq_pkg::PH_WDATA;
                        end
                    end else if (i_req.first_result != i2c_seq_pkg::RES_NACK) begin
                        n_phase = i2c_seq_pkg::PH_ERROR;
                    end
                end
                i2c_seq_pkg::PH_WDATA: begin
                    n_done = done_inc;
                    if (i_req.first_result != i2c_seq_pkg::RES_OK) begin
                        n_phase = i2c_seq_pkg::PH_ERROR;
                    end else if (done_inc == r_total) begin
                        n_phase = i2c_seq_pkg::PH_STOP;
                    end
                end
                i2c_seq_pkg::PH_WREG: begin
                    n_phase = (i_req.first_result == i2c_seq_pkg::RES_OK)
                            ? i2c_seq_pkg::PH_RESTART : i2c_seq_pkg::PH_ERROR;
                end
                i2c_seq_pkg::PH_READ: begin
                    n_done  = done_inc;
                    n_phase = i2c_seq_pkg::PH_STOP;
                end
                default: begin
                    n_phase = i2c_seq_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // result list
    always_comb begin
        case (n_phase)
            i2c_seq_pkg::PH_IDLE:  n_status = i2c_seq_pkg::ST_IDLE;
            i2c_seq_pkg::PH_ERROR: n_status = i2c_seq_pkg::ST_ERROR;
            default:               n_status = i2c_seq_pkg::ST_BUSY;
        endcase
        for (int k = 0; k < i2c_seq_pkg::MAX_RES; k++) begin
            n_res[k].primitive_res  = i2c_seq_pkg::PRIM_NONE;
            n_res[k].bus_byte       = '0;
            n_res[k].transfer_index = '0;
            n_res[k].status         = n_status;
            n_res[k].last           = 1'b0;
        end
        n_num = 2'd1;
        if (is_step && !is_cmd) begin
            case (r_phase)
                i2c_seq_pkg::PH_START, i2c_seq_pkg::PH_RESTART: begin
                    n_res[0].primitive_res = (r_phase == i2c_seq_pkg::PH_START)
                        ? i2c_seq_pkg::PRIM_START : i2c_seq_pkg::PRIM_RESTART;
                    if (i_req.first_result == i2c_seq_pkg::RES_OK) begin
                        n_res[1].primitive_res = i2c_seq_pkg::PRIM_WRITE;
                        n_res[1].bus_byte      = (r_phase == i2c_seq_pkg::PH_START)
                            ? r_addr : (r_addr | i2c_seq_pkg::READ_FLAG);
                        n_num = 2'd2;
                    end
                end
                i2c_seq_pkg::PH_WDATA: begin
                    n_res[0].primitive_res  = i2c_seq_pkg::PRIM_WRITE;
                    n_res[0].bus_byte       = i_req.buffer_byte;
                    n_res[0].transfer_index = idx_ext;
                end
                i2c_seq_pkg::PH_WREG: begin
                    n_res[0].primitive_res = i2c_seq_pkg::PRIM_WRITE;
                    n_res[0].bus_byte      = r_reg;
                end
                i2c_seq_pkg::PH_READ: begin
                    n_res[0].primitive_res  = i2c_seq_pkg::PRIM_READ;
                    n_res[0].bus_byte       = i_req.read_byte;
                    n_res[0].transfer_index = idx_ext;
                end
                default: begin
                    n_res[0].primitive_res = i2c_seq_pkg::PRIM_STOP;
                end
            endcase
            // failure closes with a stop
            if (n_phase == i2c_seq_pkg::PH_ERROR) begin
                n_res[n_num].primitive_res = i2c_seq_pkg::PRIM_STOP;
                n_num = n_num + 2'd1;
            end
        end
        n_res[n_num - 2'd1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= i2c_seq_pkg::PH_IDLE;
            r_is_rdreg <= 1'b0;
            r_addr     <= '0;
            r_reg      <= '0;
            r_done     <= '0;
            r_total    <= '0;
            r_left     <= 2'd0;
        end else begin
            if (in_acc) begin
                r_phase    <= n_phase;
                r_is_rdreg <= n_is_rdreg;
                r_addr     <= n_addr;
                r_reg      <= n_reg;
                r_done     <= n_done;
                r_total    <= n_total;
                r_left     <= n_num;
            end else if (out_acc) begin
                r_left <= r_left - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end else if (out_acc) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    `I2C_SEQ_ASSERT(a_drain_empty,
        (out_acc && o_res.last && !in_acc) |=> !o_res_valid,
        "result buffer not empty after final result")
    `I2C_SEQ_ASSERT(a_error_sticky,
        (r_phase == i2c_seq_pkg::PH_ERROR && !(in_acc && is_cmd))
            |=> (r_phase == i2c_seq_pkg::PH_ERROR),
        "error state left without a command")
    `I2C_SEQ_ASSERT(a_wdata_count,
        (r_phase == i2c_seq_pkg::PH_WDATA) |-> (r_done < r_total),
        "write count reached total inside data phase")
    `I2C_SEQ_ASSERT_ALWAYS(a_left_range,
        !i_rst_n || r_left != 2'd3 || r_res[2].last,
        "three pending results without final mark on the third")

endmodule

`default_nettype wire
